// File: design/md5_pkg.sv
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // controller to datapath
  typedef struct packed {
    logic       init_chain;   // load initial chaining words
    logic       wr_byte;      // write in byte at pos
    logic       wr_pad;       // write padding byte at pad_pos
    logic [5:0] pad_pos;
    logic       start_round;  // latch a..d from chain
    logic       do_round;     // run round round_idx
    logic [5:0] round_idx;
    logic       fold;         // add a..d into chain
  } md5_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: design/md5_datapath.sv
`default_nettype none
module md5_datapath (
  input  wire logic                clk,
  input  wire md5_pkg::md5_cmd_t   cmd,
  input  wire logic [5:0]          wr_pos,
  input  wire logic [7:0]          wr_data,
  input  wire logic [1:0]          sel_word,
  output logic [31:0]              chain_word
);

  // block buffer as sixteen little-endian words
  logic [31:0] buf_r [16];
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f, t, rot, w;
  logic [3:0]  g;
  logic [5:0]  i;

  assign i = cmd.round_idx;

  always_comb begin
    unique case (i[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = i[3:0]; end
      2'd1: begin f = (b_r & d_r) | (c_r & ~d_r); g = 4'(5 * i + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r; g = 4'(3 * i + 5); end
      default: begin f = c_r ^ (b_r | ~d_r); g = 4'(7 * i); end
    endcase
    w = buf_r[g];
    t = a_r + f + w + md5_pkg::round_k(i);
    rot = (t << md5_pkg::round_s(i)) | (t >> (6'd32 - {1'b0, md5_pkg::round_s(i)}));
  end

  // block buffer, no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      buf_r[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_data;
    end else if (cmd.wr_pad) begin
      buf_r[cmd.pad_pos[5:2]][{cmd.pad_pos[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_chain) begin
      ch_r[0] <= md5_pkg::IV_A;
      ch_r[1] <= md5_pkg::IV_B;
      ch_r[2] <= md5_pkg::IV_C;
      ch_r[3] <= md5_pkg::IV_D;
    end else if (cmd.fold) begin
      ch_r[0] <= ch_r[0] + a_r;
      ch_r[1] <= ch_r[1] + b_r;
      ch_r[2] <= ch_r[2] + c_r;
      ch_r[3] <= ch_r[3] + d_r;
    end
    if (cmd.start_round) begin
      a_r <= ch_r[0];
      b_r <= ch_r[1];
      c_r <= ch_r[2];
      d_r <= ch_r[3];
    end else if (cmd.do_round) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= rot + b_r;
    end
  end

  assign chain_word = ch_r[sel_word];

endmodule
`default_nettype wire

// File: design/md5_ctrl.sv
`default_nettype none
module md5_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_bvalid,
  input  wire logic               in_last,
  output md5_pkg::md5_cmd_t       cmd,
  output logic [5:0]              wr_pos,
  output logic [7:0]              wr_data,
  output logic [1:0]              sel_word,
  input  wire logic [31:0]        chain_word,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_word,
  output logic [1:0]              out_idx,
  output logic                    out_lastw
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_EMIT, S_WAIT
  } state_t;

  state_t      state_r;
  logic [63:0] len_r;
  logic [5:0]  cnt_r;
  logic        fin_r;   // message is being finished
  logic        pad2_r;  // this block is the second pad block
  logic [1:0]  widx_r;
  logic        ovalid_r;
  logic [31:0] oword_r;
  logic [1:0]  oidx_r;
  logic        olast_r;
  logic        acc;
  logic [5:0]  pos;
  // padding bookkeeping: whether a pad block was built, and whether a
  // second one is needed (marker landed at 56 or above)
  logic        pad_done_r, need2_r;

  assign pos = len_r[8:3];
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign wr_pos = pos;
  assign sel_word = widx_r;
  assign out_tvalid = ovalid_r;
  assign out_word = oword_r;
  assign out_idx = oidx_r;
  assign out_lastw = olast_r;

  always_comb begin
    cmd = '0;
    wr_data = in_byte;
    cmd.round_idx = cnt_r;
    cmd.pad_pos = cnt_r;
    unique case (state_r)
      S_IDLE:  cmd.wr_byte = acc && in_bvalid;
      S_START: cmd.start_round = 1'b1;
      S_ROUND: cmd.do_round = 1'b1;
      S_FOLD:  cmd.fold = 1'b1;
      S_PAD: begin
        cmd.wr_pad = 1'b1;
        // length bytes go into the final pad block only; the 0x80 marker
        // sits at the message end on the first pad block only
        if ((pad2_r || pos < 6'd56) && cnt_r >= 6'd56) begin
          wr_data = len_r[{cnt_r[2:0], 3'b000} +: 8];
        end else if (cnt_r == pos && !pad2_r) begin
          wr_data = md5_pkg::PAD_BYTE;
        end else begin
          wr_data = 8'h00;
        end
      end
      S_EMIT:  cmd.init_chain = 1'b0;
      default: cmd.init_chain = 1'b0;
    endcase
    if (state_r == S_WAIT && widx_r == 2'd3 && out_tready) cmd.init_chain = 1'b1;
    if (!rst_n) cmd.init_chain = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      pad2_r   <= 1'b0;
      widx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (acc) begin
          if (in_bvalid) len_r <= len_r + 64'd8;
          fin_r  <= in_last;
          pad2_r <= 1'b0;
          if (in_bvalid && pos == 6'd63) begin
            state_r <= S_START;
          end else if (in_last) begin
            cnt_r <= in_bvalid ? pos + 6'd1 : pos;
            state_r <= S_PAD;
          end
        end
        S_PAD: begin
          // fill from cnt_r up to 63; bytes at 56.. take the length only in the
          // final block, otherwise zero apart from the marker
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= S_START;
        end
        S_START: begin
          cnt_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (pos == 6'd0 && !pad2_r && !pad_done_r) begin
            // block ended exactly on the last byte: pad block from zero
            cnt_r <= '0;
            state_r <= S_PAD;
          end else if (need2_r) begin
            cnt_r  <= '0;
            pad2_r <= 1'b1;
            state_r <= S_PAD;
          end else begin
            widx_r  <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          ovalid_r <= 1'b1;
          oword_r  <= chain_word;
          oidx_r   <= widx_r;
          olast_r  <= (widx_r == 2'd3);
          state_r  <= S_WAIT;
        end
        default: if (out_tready) begin
          ovalid_r <= 1'b0;
          if (widx_r == 2'd3) begin
            len_r   <= '0;
            fin_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            widx_r  <= widx_r + 2'd1;
            state_r <= S_EMIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_done_r <= 1'b0;
      need2_r    <= 1'b0;
    end else if (state_r == S_IDLE) begin
      pad_done_r <= 1'b0;
      need2_r    <= 1'b0;
    end else if (state_r == S_PAD && cnt_r == 6'd63) begin
      pad_done_r <= 1'b1;
      need2_r    <= !pad2_r && (pos >= 6'd56);
    end else if (state_r == S_FOLD) begin
      need2_r    <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: design/md5_hash_engine.sv
`default_nettype none
// md5 engine: bytes enter one per transfer, taken only while idle; the 64th
// byte of a block starts a compression (one round per cycle), with input stalled
// a last transfer builds one or two pad blocks plus their compressions, then
// the four digest words leave one at a time, each held until it is taken
// synchronous active-low reset restores the initial chaining words and
// clears the length; the block buffer is not cleared
module md5_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // byte_valid
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word, word_index, zero fill
  output logic             out_tlast   // last_word
);

  md5_pkg::md5_cmd_t cmd;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_data;
  logic [1:0]  sel_word;
  logic [31:0] chain_word;
  logic [31:0] out_word;
  logic [1:0]  out_idx;

  md5_ctrl u_ctrl (
    .clk, .rst_n,
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_byte(in_tdata), .in_bvalid(in_tuser), .in_last(in_tlast),
    .cmd, .wr_pos, .wr_data, .sel_word, .chain_word,
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_word, .out_idx, .out_lastw(out_tlast)
  );

  md5_datapath u_dp (
    .clk, .cmd, .wr_pos, .wr_data, .sel_word, .chain_word
  );

  assign out_tdata = {6'b0, out_idx, out_word};

endmodule
`default_nettype wire
